/* src/dtq_pkg.sv */
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared sizes, codes and controller/datapath interface types for the
// delta-list timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

    // Sizes
    localparam int QUEUE_DEPTH = 16;
    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DELAY_W     = 32;
    localparam int ID_W        = 16;
    localparam int HANDLE_W    = 16;

    // Command codes
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_PEEK   = 2'd3
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_HEAD,
        S_INS_WALK,
        S_INS_LINKP,
        S_INS_WRNEW,
        S_RM_SCAN,
        S_RM_SUM,
        S_RM_RELINK,
        S_RM_FREE,
        S_HEAD_OUT
    } state_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_INS_HEAD_BEFORE,
        OP_INS_HEAD_AFTER,
        OP_INS_STEP,
        OP_INS_SPLIT,
        OP_INS_LINKP,
        OP_INS_WRNEW,
        OP_RM_NEXT,
        OP_RM_FOUND,
        OP_RM_SUM,
        OP_RM_RELINK,
        OP_RM_FREE,
        OP_HEAD_OUT
    } dp_op_t;

    // Controller to datapath
    typedef struct packed {
        dp_op_t  op;
        logic    done;
        status_t stat;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_empty;
        logic is_full;
        logic d_lt;
        logic le_rem;
        logic match;
        logic more;
        logic pos_zero;
    } dp_stat_t;

    // Lowest-numbered free slot
    function automatic logic [SLOT_W-1:0] first_free(input logic [QUEUE_DEPTH-1:0] used);
        logic [SLOT_W-1:0] r;
        int i;
        r = '0;
        for (i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (!used[i])
            begin
                r = SLOT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

/* src/dtq_datapath.sv */
// ----------------------------------------------------------------------------
// dtq_datapath
// Entry memory, list pointers, walk registers and result registers of the
// timer queue. Performs one operation per cycle as the controller orders.
// ----------------------------------------------------------------------------
module dtq_datapath import dtq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          command,
    input  logic [DELAY_W-1:0]  delay,
    input  logic [ID_W-1:0]     txn_id,
    input  logic [HANDLE_W-1:0] handle,
    input  dp_cmd_t             ctl,
    output dp_stat_t            stat,
    output logic                done,
    output logic [1:0]          status,
    output logic [ID_W-1:0]     out_id,
    output logic [DELAY_W-1:0]  out_delay,
    output logic [HANDLE_W-1:0] out_handle,
    output logic                queue_empty
);

    // Entry memory
    logic [DELAY_W-1:0]  mem_delay [QUEUE_DEPTH];
    logic [ID_W-1:0]     mem_txn   [QUEUE_DEPTH];
    logic [HANDLE_W-1:0] mem_pay   [QUEUE_DEPTH];
    logic [SLOT_W-1:0]   mem_link  [QUEUE_DEPTH];

    // Registered read word
    logic [DELAY_W-1:0]  rd_delay_reg;
    logic [ID_W-1:0]     rd_txn_reg;
    logic [HANDLE_W-1:0] rd_pay_reg;
    logic [SLOT_W-1:0]   rd_link_reg;

    // Latched command word and walk registers
    cmd_t                cmd_reg;
    logic [DELAY_W-1:0]  d_reg;
    logic [ID_W-1:0]     id_reg;
    logic [HANDLE_W-1:0] h_reg;
    logic [DELAY_W-1:0]  rem_reg;
    logic [SLOT_W-1:0]   s_reg;
    logic [SLOT_W-1:0]   nlink_reg;
    logic [SLOT_W-1:0]   p_reg;
    logic [SLOT_W-1:0]   prev_reg;
    logic [SLOT_W-1:0]   cur_reg;
    logic [CNT_W-1:0]    pos_reg;

    // List state
    logic [SLOT_W-1:0]      head_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [QUEUE_DEPTH-1:0] used_reg;

    // Result registers
    logic                done_reg;
    status_t             status_reg;
    logic [ID_W-1:0]     out_id_reg;
    logic [DELAY_W-1:0]  out_delay_reg;
    logic [HANDLE_W-1:0] out_handle_reg;

    // Memory access controls
    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    logic                wr_delay_en;
    logic                wr_link_en;
    logic                wr_ent_en;
    logic [SLOT_W-1:0]   wr_addr;
    logic [DELAY_W-1:0]  wr_delay;
    logic [SLOT_W-1:0]   wr_link;

    logic [DELAY_W:0]    sum_w;
    logic [DELAY_W-1:0]  sat_sum;
    logic [SLOT_W-1:0]   free_slot;

    assign sum_w     = {1'b0, rd_delay_reg} + {1'b0, rem_reg};
    assign sat_sum   = sum_w[DELAY_W] ? {DELAY_W{1'b1}} : sum_w[DELAY_W-1:0];
    assign free_slot = first_free(used_reg);

    // Decode operation into memory accesses
    always_comb
    begin
        rd_en       = 1'b0;
        rd_addr     = rd_link_reg;
        wr_delay_en = 1'b0;
        wr_link_en  = 1'b0;
        wr_ent_en   = 1'b0;
        wr_addr     = cur_reg;
        wr_delay    = rd_delay_reg - rem_reg;
        wr_link     = nlink_reg;
        case (ctl.op)
            OP_ACCEPT:
            begin
                rd_en   = 1'b1;
                rd_addr = head_reg;
            end
            OP_INS_HEAD_AFTER, OP_INS_STEP, OP_RM_NEXT, OP_RM_FOUND:
            begin
                rd_en = 1'b1;
            end
            OP_INS_HEAD_BEFORE:
            begin
                wr_delay_en = 1'b1;
                wr_delay    = rd_delay_reg - d_reg;
            end
            OP_INS_SPLIT:
            begin
                wr_delay_en = 1'b1;
            end
            OP_INS_LINKP:
            begin
                wr_link_en = 1'b1;
                wr_addr    = p_reg;
                wr_link    = s_reg;
            end
            OP_INS_WRNEW:
            begin
                wr_delay_en = 1'b1;
                wr_link_en  = 1'b1;
                wr_ent_en   = 1'b1;
                wr_addr     = s_reg;
                wr_delay    = rem_reg;
            end
            OP_RM_SUM:
            begin
                wr_delay_en = 1'b1;
                wr_delay    = sat_sum;
            end
            OP_RM_RELINK:
            begin
                wr_link_en = 1'b1;
                wr_addr    = prev_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Entry memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_delay_en)
        begin
            mem_delay[wr_addr] <= wr_delay;
        end
        if (wr_link_en)
        begin
            mem_link[wr_addr] <= wr_link;
        end
        if (wr_ent_en)
        begin
            mem_txn[wr_addr] <= id_reg;
            mem_pay[wr_addr] <= h_reg;
        end
        if (rd_en)
        begin
            rd_delay_reg <= mem_delay[rd_addr];
            rd_txn_reg   <= mem_txn[rd_addr];
            rd_pay_reg   <= mem_pay[rd_addr];
            rd_link_reg  <= mem_link[rd_addr];
        end
    end

    // Walk registers and result fields
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            cur_reg <= rd_addr;
        end
        case (ctl.op)
            OP_ACCEPT:
            begin
                cmd_reg        <= cmd_t'(command);
                d_reg          <= delay;
                id_reg         <= txn_id;
                h_reg          <= handle;
                rem_reg        <= delay;
                s_reg          <= free_slot;
                nlink_reg      <= free_slot;
                pos_reg        <= '0;
                prev_reg       <= head_reg;
                out_id_reg     <= '0;
                out_delay_reg  <= '0;
                out_handle_reg <= '0;
            end
            OP_INS_HEAD_BEFORE, OP_INS_SPLIT, OP_RM_SUM:
            begin
                nlink_reg <= cur_reg;
            end
            OP_INS_HEAD_AFTER:
            begin
                rem_reg <= d_reg - rd_delay_reg;
                p_reg   <= cur_reg;
                pos_reg <= CNT_W'(1);
            end
            OP_INS_STEP:
            begin
                rem_reg <= rem_reg - rd_delay_reg;
                p_reg   <= cur_reg;
                pos_reg <= pos_reg + CNT_W'(1);
            end
            OP_RM_NEXT:
            begin
                prev_reg <= cur_reg;
                pos_reg  <= pos_reg + CNT_W'(1);
            end
            OP_RM_FOUND:
            begin
                out_id_reg     <= rd_txn_reg;
                out_delay_reg  <= rd_delay_reg;
                out_handle_reg <= rd_pay_reg;
                rem_reg        <= rd_delay_reg;
                s_reg          <= cur_reg;
                nlink_reg      <= prev_reg;
            end
            OP_HEAD_OUT:
            begin
                out_id_reg     <= rd_txn_reg;
                out_delay_reg  <= rd_delay_reg;
                out_handle_reg <= rd_pay_reg;
            end
            default:
            begin
            end
        endcase
    end

    // List state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            used_reg   <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            done_reg <= ctl.done;
            if (ctl.done)
            begin
                status_reg <= ctl.stat;
            end
            case (ctl.op)
                OP_INS_HEAD_BEFORE:
                begin
                    head_reg <= s_reg;
                end
                OP_INS_WRNEW:
                begin
                    used_reg[s_reg] <= 1'b1;
                    count_reg       <= count_reg + CNT_W'(1);
                    if (count_reg == '0)
                    begin
                        head_reg <= s_reg;
                    end
                end
                OP_RM_SUM:
                begin
                    if (pos_reg == '0)
                    begin
                        head_reg <= cur_reg;
                    end
                end
                OP_RM_FREE:
                begin
                    used_reg[s_reg] <= 1'b0;
                    count_reg       <= count_reg - CNT_W'(1);
                end
                OP_HEAD_OUT:
                begin
                    if (cmd_reg == CMD_POP)
                    begin
                        if (count_reg > CNT_W'(1))
                        begin
                            head_reg <= rd_link_reg;
                        end
                        used_reg[cur_reg] <= 1'b0;
                        count_reg         <= count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Status to controller
    assign stat.is_empty = (count_reg == '0);
    assign stat.is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.d_lt     = (d_reg < rd_delay_reg);
    assign stat.le_rem   = (rd_delay_reg <= rem_reg);
    assign stat.match    = (rd_txn_reg == id_reg);
    assign stat.more     = (({1'b0, pos_reg} + (CNT_W+1)'(1)) < {1'b0, count_reg});
    assign stat.pos_zero = (pos_reg == '0);

    // Result ports
    assign done        = done_reg;
    assign status      = status_reg;
    assign out_id      = out_id_reg;
    assign out_delay   = out_delay_reg;
    assign out_handle  = out_handle_reg;
    assign queue_empty = (count_reg == '0);

endmodule

/* src/dtq_ctrl.sv */
// ----------------------------------------------------------------------------
// dtq_ctrl
// Sequencer of the timer queue: decodes the command word and steps the
// datapath through the list walk, one entry per cycle.
// ----------------------------------------------------------------------------
module dtq_ctrl import dtq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] command,
    input  dp_stat_t   stat,
    output dp_cmd_t    ctl,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        ctl.op     = OP_NONE;
        ctl.done   = 1'b0;
        ctl.stat   = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.op = OP_ACCEPT;
                    case (cmd_t'(command))
                        CMD_INSERT:
                        begin
                            if (stat.is_full)
                            begin
                                ctl.done = 1'b1;
                                ctl.stat = ST_FULL;
                            end
                            else if (stat.is_empty)
                            begin
                                state_next = S_INS_WRNEW;
                            end
                            else
                            begin
                                state_next = S_INS_HEAD;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (stat.is_empty)
                            begin
                                ctl.done = 1'b1;
                                ctl.stat = ST_MISS;
                            end
                            else
                            begin
                                state_next = S_RM_SCAN;
                            end
                        end
                        default:
                        begin
                            if (stat.is_empty)
                            begin
                                ctl.done = 1'b1;
                                ctl.stat = ST_MISS;
                            end
                            else
                            begin
                                state_next = S_HEAD_OUT;
                            end
                        end
                    endcase
                end
            end
            // head word is in the read register
            S_INS_HEAD:
            begin
                if (stat.d_lt)
                begin
                    ctl.op     = OP_INS_HEAD_BEFORE;
                    state_next = S_INS_WRNEW;
                end
                else
                begin
                    ctl.op     = OP_INS_HEAD_AFTER;
                    state_next = stat.more ? S_INS_WALK : S_INS_LINKP;
                end
            end
            // successor of p is in the read register
            S_INS_WALK:
            begin
                if (stat.le_rem)
                begin
                    ctl.op     = OP_INS_STEP;
                    state_next = stat.more ? S_INS_WALK : S_INS_LINKP;
                end
                else
                begin
                    ctl.op     = OP_INS_SPLIT;
                    state_next = S_INS_LINKP;
                end
            end
            S_INS_LINKP:
            begin
                ctl.op     = OP_INS_LINKP;
                state_next = S_INS_WRNEW;
            end
            S_INS_WRNEW:
            begin
                ctl.op     = OP_INS_WRNEW;
                ctl.done   = 1'b1;
                ctl.stat   = ST_OK;
                state_next = S_IDLE;
            end
            // search for a matching id
            S_RM_SCAN:
            begin
                if (stat.match)
                begin
                    ctl.op = OP_RM_FOUND;
                    if (stat.more)
                    begin
                        state_next = S_RM_SUM;
                    end
                    else if (!stat.pos_zero)
                    begin
                        state_next = S_RM_RELINK;
                    end
                    else
                    begin
                        state_next = S_RM_FREE;
                    end
                end
                else if (stat.more)
                begin
                    ctl.op = OP_RM_NEXT;
                end
                else
                begin
                    ctl.done   = 1'b1;
                    ctl.stat   = ST_MISS;
                    state_next = S_IDLE;
                end
            end
            S_RM_SUM:
            begin
                ctl.op     = OP_RM_SUM;
                state_next = stat.pos_zero ? S_RM_FREE : S_RM_RELINK;
            end
            S_RM_RELINK:
            begin
                ctl.op     = OP_RM_RELINK;
                state_next = S_RM_FREE;
            end
            S_RM_FREE:
            begin
                ctl.op     = OP_RM_FREE;
                ctl.done   = 1'b1;
                ctl.stat   = ST_OK;
                state_next = S_IDLE;
            end
            S_HEAD_OUT:
            begin
                ctl.op     = OP_HEAD_OUT;
                ctl.done   = 1'b1;
                ctl.stat   = ST_OK;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* src/delta_timer_queue_core.sv */
// ----------------------------------------------------------------------------
// delta_timer_queue_core
// Bounded delta-list timer queue with insert, pop, remove-by-id and peek.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (command, delay, txn_id, handle) is taken at a rising edge
//   where start is high and busy is low. Exactly one result word follows:
//   done is high for one cycle and status, out_id, out_delay, out_handle and
//   queue_empty are valid in that cycle. The receiver cannot stall; a result
//   not sampled in its cycle is gone.
// List walk:
//   full or empty failures are answered without a walk; insert and remove
//   walk the linked list through the entry memory at one entry per cycle.
// Throughput:
//   one command at a time; busy drops in the cycle done is raised, so the
//   next command may be taken while the result is still shown.
// Reset:
//   rst_n clears the queue to empty; entry memory is not cleared, as every
//   slot is fully written when it is allocated.
// ----------------------------------------------------------------------------
module delta_timer_queue_core import dtq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          command,
    input  logic [DELAY_W-1:0]  delay,
    input  logic [ID_W-1:0]     txn_id,
    input  logic [HANDLE_W-1:0] handle,
    output logic                done,
    output logic [1:0]          status,
    output logic [ID_W-1:0]     out_id,
    output logic [DELAY_W-1:0]  out_delay,
    output logic [HANDLE_W-1:0] out_handle,
    output logic                queue_empty
);

    dp_cmd_t  ctl;
    dp_stat_t stat;

    // Sequencer
    dtq_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .ctl     (ctl),
        .busy    (busy)
    );

    // Entry store and list datapath
    dtq_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .command     (command),
        .delay       (delay),
        .txn_id      (txn_id),
        .handle      (handle),
        .ctl         (ctl),
        .stat        (stat),
        .done        (done),
        .status      (status),
        .out_id      (out_id),
        .out_delay   (out_delay),
        .out_handle  (out_handle),
        .queue_empty (queue_empty)
    );

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for delta_timer_queue_core. A short scripted run covers
// the empty, full, tie and extreme-delay cases, then about nine hundred random
// command words sweep the fill level between empty and full. Every result
// word is checked against a scripted value or an in-bench delta-list model.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dtq_pkg::*;

    localparam int RANDOM_WORDS = 900;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = QUEUE_DEPTH + 8;

    typedef struct {
        status_t             st;
        logic [ID_W-1:0]     id;
        logic [DELAY_W-1:0]  dly;
        logic [HANDLE_W-1:0] hdl;
        logic                empty;
    } result_t;

    typedef struct {
        cmd_t                cmd;
        logic [DELAY_W-1:0]  dly;
        logic [ID_W-1:0]     id;
        logic [HANDLE_W-1:0] hdl;
        bit                  known;
        result_t             res;
    } cmd_word_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          command;
    logic [DELAY_W-1:0]  delay;
    logic [ID_W-1:0]     txn_id;
    logic [HANDLE_W-1:0] handle;
    logic                done;
    logic [1:0]          status;
    logic [ID_W-1:0]     out_id;
    logic [DELAY_W-1:0]  out_delay;
    logic [HANDLE_W-1:0] out_handle;
    logic                queue_empty;

    // Model of the delta list
    logic [DELAY_W-1:0]  tl_delay  [QUEUE_DEPTH];
    logic [ID_W-1:0]     tl_txn    [QUEUE_DEPTH];
    logic [HANDLE_W-1:0] tl_handle [QUEUE_DEPTH];
    logic [SLOT_W-1:0]   tl_link   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] tl_used;
    logic [SLOT_W-1:0]   tl_head;
    int                  tl_count;

    result_t   pending_results[$];
    cmd_word_t script[$];
    int        error_count;
    int        idle_cycles;
    bit        no_idle;

    delta_timer_queue_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .delay       (delay),
        .txn_id      (txn_id),
        .handle      (handle),
        .done        (done),
        .status      (status),
        .out_id      (out_id),
        .out_delay   (out_delay),
        .out_handle  (out_handle),
        .queue_empty (queue_empty)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one command word to the list model and return its result word
    task automatic timer_list_apply(input cmd_t cmd, input logic [DELAY_W-1:0] d,
                                    input logic [ID_W-1:0] id,
                                    input logic [HANDLE_W-1:0] h, output result_t r);
        int                n;
        int                pos;
        bit                found;
        logic [SLOT_W-1:0] s;
        logic [SLOT_W-1:0] p;
        logic [SLOT_W-1:0] cur;
        logic [SLOT_W-1:0] prev;
        logic [SLOT_W-1:0] nx;
        logic [DELAY_W-1:0] rem;
        logic [DELAY_W:0]  sum;
        r.st    = ST_OK;
        r.id    = '0;
        r.dly   = '0;
        r.hdl   = '0;
        n       = tl_count;
        case (cmd)
            CMD_INSERT:
            begin
                if (n >= QUEUE_DEPTH)
                begin
                    r.st = ST_FULL;
                end
                else
                begin
                    // lowest free slot
                    s     = '0;
                    found = 1'b0;
                    for (int i = 0; i < QUEUE_DEPTH; i++)
                    begin
                        if (!found && !tl_used[i])
                        begin
                            s     = SLOT_W'(i);
                            found = 1'b1;
                        end
                    end
                    tl_used[s]   = 1'b1;
                    tl_txn[s]    = id;
                    tl_handle[s] = h;
                    tl_link[s]   = s;
                    if (n == 0)
                    begin
                        tl_delay[s] = d;
                        tl_head     = s;
                    end
                    else if (d < tl_delay[tl_head])
                    begin
                        // new head; old head rebased
                        tl_delay[tl_head] = tl_delay[tl_head] - d;
                        tl_delay[s]       = d;
                        tl_link[s]        = tl_head;
                        tl_head           = s;
                    end
                    else
                    begin
                        // walk past every entry due at or before d
                        p   = tl_head;
                        rem = d - tl_delay[p];
                        pos = 1;
                        while (pos < n && tl_delay[tl_link[p]] <= rem)
                        begin
                            p   = tl_link[p];
                            rem = rem - tl_delay[p];
                            pos++;
                        end
                        if (pos < n)
                        begin
                            tl_delay[tl_link[p]] = tl_delay[tl_link[p]] - rem;
                            tl_link[s]           = tl_link[p];
                        end
                        tl_link[p]  = s;
                        tl_delay[s] = rem;
                    end
                    tl_count = n + 1;
                end
            end
            CMD_REMOVE:
            begin
                pos  = 0;
                cur  = tl_head;
                prev = tl_head;
                while (pos < n && tl_txn[cur] != id)
                begin
                    prev = cur;
                    cur  = tl_link[cur];
                    pos++;
                end
                if (pos >= n)
                begin
                    r.st = ST_MISS;
                end
                else
                begin
                    r.id  = tl_txn[cur];
                    r.dly = tl_delay[cur];
                    r.hdl = tl_handle[cur];
                    if (pos + 1 < n)
                    begin
                        // successor takes over the removed delay, saturating
                        nx  = tl_link[cur];
                        sum = {1'b0, tl_delay[nx]} + {1'b0, tl_delay[cur]};
                        tl_delay[nx] = sum[DELAY_W] ? '1 : sum[DELAY_W-1:0];
                        if (pos == 0)
                            tl_head = nx;
                        else
                            tl_link[prev] = nx;
                    end
                    else if (pos > 0)
                    begin
                        tl_link[prev] = prev;
                    end
                    tl_used[cur] = 1'b0;
                    tl_count     = n - 1;
                end
            end
            default:
            begin
                // pop and peek
                if (n == 0)
                begin
                    r.st = ST_MISS;
                end
                else
                begin
                    cur   = tl_head;
                    r.id  = tl_txn[cur];
                    r.dly = tl_delay[cur];
                    r.hdl = tl_handle[cur];
                    if (cmd == CMD_POP)
                    begin
                        if (n > 1)
                            tl_head = tl_link[cur];
                        tl_used[cur] = 1'b0;
                        tl_count     = n - 1;
                    end
                end
            end
        endcase
        r.empty = (tl_count == 0);
    endtask

    // Sender gap: mostly short, a few long
    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (no_idle || k < 40)
            return 0;
        else if (k < 85)
            return $urandom_range(1, 3);
        else if (k < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Drive one command word and record what it should return
    task automatic issue_word(input cmd_word_t w);
        int      gap;
        result_t r;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        command <= w.cmd;
        delay   <= w.dly;
        txn_id  <= w.id;
        handle  <= w.hdl;
        do @(posedge clk); while (busy);
        timer_list_apply(w.cmd, w.dly, w.id, w.hdl, r);
        if (w.known)
            pending_results.push_back(w.res);
        else
            pending_results.push_back(r);
        @(negedge clk);
    endtask

    task automatic add_row(input cmd_t cmd, input logic [DELAY_W-1:0] d,
                           input logic [ID_W-1:0] id, input logic [HANDLE_W-1:0] h,
                           input bit known, input status_t st,
                           input logic [ID_W-1:0] rid, input logic [DELAY_W-1:0] rd,
                           input logic [HANDLE_W-1:0] rh, input logic re);
        cmd_word_t w;
        w.cmd       = cmd;
        w.dly       = d;
        w.id        = id;
        w.hdl       = h;
        w.known     = known;
        w.res.st    = st;
        w.res.id    = rid;
        w.res.dly   = rd;
        w.res.hdl   = rh;
        w.res.empty = re;
        script.push_back(w);
    endtask

    // Random delay: ties and small values often, extremes now and then
    function automatic logic [DELAY_W-1:0] pick_delay();
        int k;
        k = $urandom_range(0, 9);
        if (k < 3)
            return $urandom_range(0, 15);
        else if (k == 3)
            return '0;
        else if (k == 4)
            return '1;
        else
            return $urandom;
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 1) == 0)
            return ID_W'($urandom_range(0, 7));
        else
            return ID_W'($urandom_range(0, 16'hFFFF));
    endfunction

    // Id of some entry now in the list
    function automatic logic [ID_W-1:0] live_txn();
        int s;
        s = $urandom_range(0, QUEUE_DEPTH - 1);
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (tl_used[(s + i) % QUEUE_DEPTH])
                return tl_txn[(s + i) % QUEUE_DEPTH];
        end
        return pick_id();
    endfunction

    // Random word, steered towards a target fill level
    function automatic cmd_word_t random_word(input int target);
        cmd_word_t w;
        int        k;
        int        ins_w;
        int        pop_w;
        int        rem_w;
        k = $urandom_range(0, 99);
        if (tl_count < target)
        begin
            ins_w = 65; pop_w = 10; rem_w = 15;
        end
        else if (tl_count > target)
        begin
            ins_w = 15; pop_w = 35; rem_w = 35;
        end
        else
        begin
            ins_w = 25; pop_w = 25; rem_w = 25;
        end
        if (k < ins_w)
            w.cmd = CMD_INSERT;
        else if (k < ins_w + pop_w)
            w.cmd = CMD_POP;
        else if (k < ins_w + pop_w + rem_w)
            w.cmd = CMD_REMOVE;
        else
            w.cmd = CMD_PEEK;
        w.dly   = pick_delay();
        w.hdl   = HANDLE_W'($urandom_range(0, 16'hFFFF));
        w.known = 1'b0;
        w.res   = '{ST_OK, '0, '0, '0, 1'b0};
        if (w.cmd == CMD_REMOVE && tl_count > 0 && $urandom_range(0, 4) != 0)
            w.id = live_txn();
        else
            w.id = pick_id();
        return w;
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: result word with none expected: st=%0d id=%h dly=%h hdl=%h e=%b",
                             $realtime, status, out_id, out_delay, out_handle, queue_empty);
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.st || out_id !== e.id || out_delay !== e.dly ||
                    out_handle !== e.hdl || queue_empty !== e.empty)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("%0t: mismatch exp st=%0d id=%h dly=%h hdl=%h e=%b",
                                 $realtime, e.st, e.id, e.dly, e.hdl, e.empty);
                        $display("%0t:          got st=%0d id=%h dly=%h hdl=%h e=%b",
                                 $realtime, status, out_id, out_delay, out_handle, queue_empty);
                    end
                end
            end
        end
    end

    // Watchdog on cycles where no word moves
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("delta_timer_queue_core regression: fail");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int target;
        int k;
        rst_n       = 1'b0;
        start       = 1'b0;
        command     = CMD_INSERT;
        delay       = '0;
        txn_id      = '0;
        handle      = '0;
        tl_used     = '0;
        tl_head     = '0;
        tl_count    = 0;
        error_count = 0;
        idle_cycles = 0;
        no_idle     = 1'b0;
        target      = 0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            tl_delay[i]  = '0;
            tl_txn[i]    = '0;
            tl_handle[i] = '0;
            tl_link[i]   = '0;
        end

        // Scripted words: empty queue, extremes, ties, tail removal, full
        add_row(CMD_POP,    '0, '0, '0, 1, ST_MISS, '0, '0, '0, 1'b1);
        add_row(CMD_PEEK,   '0, '0, '0, 1, ST_MISS, '0, '0, '0, 1'b1);
        add_row(CMD_REMOVE, '0, '0, '0, 1, ST_MISS, '0, '0, '0, 1'b1);
        add_row(CMD_INSERT, '1, '1, '1, 1, ST_OK,   '0, '0, '0, 1'b0);
        add_row(CMD_PEEK,   '0, '0, '0, 1, ST_OK,   '1, '1, '1, 1'b0);
        add_row(CMD_INSERT, '0, '0, '0, 1, ST_OK,   '0, '0, '0, 1'b0);
        add_row(CMD_PEEK,   '1, '1, '1, 1, ST_OK,   '0, '0, '0, 1'b0);
        add_row(CMD_INSERT, 32'd0,   16'd1, 16'h5A5A, 0, ST_OK, '0, '0, '0, 1'b0);
        add_row(CMD_INSERT, 32'd100, 16'd2, 16'hA5A5, 0, ST_OK, '0, '0, '0, 1'b0);
        add_row(CMD_REMOVE, '0, 16'd1,    '0, 0, ST_OK, '0, '0, '0, 1'b0);
        add_row(CMD_REMOVE, '0, 16'hFFFF, '0, 0, ST_OK, '0, '0, '0, 1'b0);
        add_row(CMD_REMOVE, '0, 16'h1234, '0, 1, ST_MISS, '0, '0, '0, 1'b0);
        add_row(CMD_POP,    '0, '0, '0, 0, ST_OK, '0, '0, '0, 1'b0);
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            add_row(CMD_INSERT, $urandom_range(0, 300), ID_W'(16'h100 + i),
                    HANDLE_W'($urandom_range(0, 16'hFFFF)), 0, ST_OK, '0, '0, '0, 1'b0);
        add_row(CMD_INSERT, 32'd5, 16'h0BAD, 16'h0BAD, 1, ST_FULL, '0, '0, '0, 1'b0);

        // Reset
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[i])
            issue_word(script[i]);

        // Random words, with a moving fill target
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 40 == 0)
            begin
                k = $urandom_range(0, 5);
                if (k == 0)
                    target = 0;
                else if (k == 1)
                    target = QUEUE_DEPTH;
                else
                    target = $urandom_range(1, QUEUE_DEPTH - 1);
            end
            if (i % 100 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            issue_word(random_word(target));
        end
        start <= 1'b0;

        // Drain
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("delta_timer_queue_core regression: pass");
        else
            $display("delta_timer_queue_core regression: fail");
        $finish;
    end

endmodule

/* files.f */
src/dtq_pkg.sv
src/dtq_datapath.sv
src/dtq_ctrl.sv
src/delta_timer_queue_core.sv
dv/tb_top.sv
